### rtl/ceq_pkg.sv
// ============================================================================
// ceq_pkg - shared types and constants for the coalescing event queue
// Kind codes, the queue entry record and the control record broadcast to cells.
// ============================================================================
package ceq_pkg;

    localparam int DEPTH_DEF = 16;

    // event kind codes
    localparam logic [3:0] K_OTHER    = 4'd0;
    localparam logic [3:0] K_POKE     = 4'd1;
    localparam logic [3:0] K_SCREATE  = 4'd2;
    localparam logic [3:0] K_SDESTROY = 4'd3;
    localparam logic [3:0] K_CPAUSE   = 4'd4;
    localparam logic [3:0] K_CRESUME  = 4'd5;
    localparam logic [3:0] K_DRAW     = 4'd6;
    localparam logic [3:0] K_VIEW     = 4'd7;
    localparam logic [3:0] K_MOTION   = 4'd8;

    // op codes
    localparam logic OP_POST = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam int DROP_W = 5;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [14:0] w;
        logic [14:0] h;
    } t_rect;

    typedef struct packed {
        logic        valid;
        logic [3:0]  kind;
        logic        mv;
        t_rect       rect;
        logic [15:0] tag;
        logic        dm;
        logic        vm;
    } t_entry;

    // commands broadcast to every cell
    typedef struct packed {
        logic kill_create;
        logic kill_dmark;
        logic kill_vmark;
        logic kill_lastmove;
        logic kill_head;
        logic compact;
        logic insert;
        logic ins_run;      // insert after the leading compositor run
        logic clr_vmark;
    } t_ctl;

endpackage

### rtl/ceq_cell.sv
// ============================================================================
// ceq_cell - one slot of the queue chain
// Holds one entry; kills, shifts toward the head, or opens room for an insert.
// ============================================================================
module ceq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ceq_pkg::t_ctl   i_ctl,
    input  logic [CW-1:0]   i_fill,
    input  logic [CW-1:0]   i_ins_pos,
    input  ceq_pkg::t_entry i_prev,
    input  ceq_pkg::t_entry i_next,
    input  ceq_pkg::t_entry i_new,
    input  logic            i_hole_in,
    output logic            o_hole_out,
    input  logic            i_crun_in,
    output logic            o_crun_out,
    output logic            o_pending,
    output ceq_pkg::t_entry o_entry
);

    ceq_pkg::t_entry r_ent;
    ceq_pkg::t_entry n_ent;
    logic            w_run;
    logic            w_kill;
    logic            w_here;
    logic            w_after;
    logic            w_last;
    logic [CW:0]     w_idx1;

    assign w_idx1 = (CW+1)'(IDX + 1);
    assign w_last = (w_idx1 == {1'b0, i_fill});
    assign w_run  = r_ent.valid &&
                    (r_ent.kind == ceq_pkg::K_CPAUSE || r_ent.kind == ceq_pkg::K_CRESUME);

    // prefix chains
    assign o_hole_out = i_hole_in | ~r_ent.valid;
    assign o_crun_out = i_crun_in & w_run;
    assign o_pending  = ~r_ent.valid && ((CW+1)'(IDX) < {1'b0, i_fill});
    assign o_entry    = r_ent;

    // removal match
    assign w_kill = r_ent.valid && (
        (i_ctl.kill_create && r_ent.kind == ceq_pkg::K_SCREATE) ||
        (i_ctl.kill_dmark && r_ent.dm) ||
        (i_ctl.kill_vmark && r_ent.vm) ||
        (i_ctl.kill_lastmove && w_last && r_ent.kind == ceq_pkg::K_MOTION && r_ent.mv) ||
        (i_ctl.kill_head && IDX == 0));

    // insert position
    always_comb begin
        if (i_ctl.ins_run) begin
            w_here  = i_crun_in & ~w_run;
            w_after = ~i_crun_in;
        end else begin
            w_here  = ((CW+1)'(IDX) == {1'b0, i_ins_pos});
            w_after = ((CW+1)'(IDX) >  {1'b0, i_ins_pos});
        end
    end

    // next slot contents
    always_comb begin
        n_ent = r_ent;
        if (w_kill) begin
            n_ent.valid = 1'b0;
        end
        if (i_ctl.compact && (i_hole_in | ~r_ent.valid)) begin
            n_ent = i_next;
        end else if (i_ctl.insert) begin
            if (w_here) begin
                n_ent = i_new;
            end else if (w_after) begin
                n_ent = i_prev;
            end
            if (i_ctl.clr_vmark) begin
                n_ent.vm = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
            r_ent.dm    <= 1'b0;
            r_ent.vm    <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
            r_ent.dm    <= n_ent.dm;
            r_ent.vm    <= n_ent.vm;
        end
        r_ent.kind <= n_ent.kind;
        r_ent.mv   <= n_ent.mv;
        r_ent.rect <= n_ent.rect;
        r_ent.tag  <= n_ent.tag;
    end

endmodule

### rtl/ceq_union.sv
// ============================================================================
// ceq_union - two-stage rectangle union
// Bounding box of the queued and new draw rectangles, size saturated.
// ============================================================================
module ceq_union (
    input  logic           i_clk,
    input  ceq_pkg::t_rect i_a,       // queued rectangle
    input  logic           i_a_ok,    // a queued rectangle exists
    input  ceq_pkg::t_rect i_b,       // new rectangle
    output ceq_pkg::t_rect o_res
);

    localparam logic signed [17:0] SAT = 18'sd32767;

    logic                  r_a_e, r_b_e;
    ceq_pkg::t_rect        r_a, r_b;
    logic signed [15:0]    r_mx, r_my;
    logic signed [16:0]    r_ra, r_rb, r_ba, r_bb;
    logic signed [16:0]    w_ra, w_rb, w_ba, w_bb, w_r, w_btm;
    logic signed [17:0]    w_w, w_h;
    ceq_pkg::t_rect        w_u;

    assign w_ra = $signed({i_a.x[15], i_a.x}) + $signed({2'b00, i_a.w});
    assign w_rb = $signed({i_b.x[15], i_b.x}) + $signed({2'b00, i_b.w});
    assign w_ba = $signed({i_a.y[15], i_a.y}) + $signed({2'b00, i_a.h});
    assign w_bb = $signed({i_b.y[15], i_b.y}) + $signed({2'b00, i_b.h});

    // stage 1: minima and far edges
    always_ff @(posedge i_clk) begin
        r_a   <= i_a;
        r_b   <= i_b;
        r_a_e <= ~i_a_ok || i_a.w == '0 || i_a.h == '0;
        r_b_e <= i_b.w == '0 || i_b.h == '0;
        r_mx  <= ($signed(i_a.x) < $signed(i_b.x)) ? $signed(i_a.x) : $signed(i_b.x);
        r_my  <= ($signed(i_a.y) < $signed(i_b.y)) ? $signed(i_a.y) : $signed(i_b.y);
        r_ra  <= w_ra;
        r_rb  <= w_rb;
        r_ba  <= w_ba;
        r_bb  <= w_bb;
    end

    // stage 2: size and selection
    assign w_r   = (r_ra > r_rb) ? r_ra : r_rb;
    assign w_btm = (r_ba > r_bb) ? r_ba : r_bb;
    assign w_w   = {w_r[16], w_r} - {{2{r_mx[15]}}, r_mx};
    assign w_h   = {w_btm[16], w_btm} - {{2{r_my[15]}}, r_my};

    always_comb begin
        w_u.x = r_mx;
        w_u.y = r_my;
        w_u.w = (w_w > SAT) ? 15'h7fff : w_w[14:0];
        w_u.h = (w_h > SAT) ? 15'h7fff : w_h[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_a_e) begin
            o_res <= r_b;
        end else if (r_b_e) begin
            o_res <= r_a;
        end else begin
            o_res <= w_u;
        end
    end

endmodule

### rtl/coalescing_event_queue.sv
// A pop from an empty queue or a post to a full queue goes straight to the result;
// any other item passes through compaction, a post also through insertion, and a draw
// also through the union; compaction repeats per entry removed by coalescing or purge.
// Throughput: one item in flight; the next input beat is taken in the cycle after the
// result is loaded, and a result still waiting on the master side holds the item.
// Reset: synchronous, active low; empties the queue and clears all marks.
// ============================================================================
// coalescing_event_queue - bounded event queue with per-kind coalescing
// Chain of slot cells with a sequencer for kill, compaction and insertion.
// ============================================================================
module coalescing_event_queue #(
    parameter int QUEUE_DEPTH = ceq_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,  // is_move, rect_x, rect_y, rect_w, rect_h, tag, pad
    input  logic [4:0]  i_s_tuser,  // op, kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,  // out_move, out_x, out_y, out_w, out_h, out_tag,
                                    // dropped, pad
    output logic [5:0]  o_m_tuser   // ok, full_res, out_kind
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECIDE  = 3'd1;
    localparam logic [2:0] S_COMPACT = 3'd2;
    localparam logic [2:0] S_UNION   = 3'd3;
    localparam logic [2:0] S_INSERT  = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_fill;
    logic              r_op;
    logic [3:0]        r_kind;
    logic              r_mv;
    ceq_pkg::t_rect    r_rect;
    logic [15:0]       r_tag;
    ceq_pkg::t_rect    r_old;
    logic              r_have_old;
    logic              r_ok, r_full;
    ceq_pkg::t_entry   r_rent;
    logic [ceq_pkg::DROP_W-1:0] r_drop;
    logic              r_ovalid;
    logic [87:0]       r_odata;
    logic [5:0]        r_ouser;

    ceq_pkg::t_ctl     w_ctl;
    ceq_pkg::t_entry   w_ent   [QUEUE_DEPTH];
    ceq_pkg::t_entry   w_new;
    ceq_pkg::t_rect    w_urect;
    ceq_pkg::t_rect    w_mrect;
    logic              w_have;
    logic [QUEUE_DEPTH:0] w_hole;
    logic [QUEUE_DEPTH:0] w_crun;
    logic [QUEUE_DEPTH-1:0] w_pend;
    logic              w_full, w_empty, w_free;
    logic [CW-1:0]     w_ins_pos;

    assign w_full  = (r_fill == CW'(QUEUE_DEPTH));
    assign w_empty = (r_fill == '0);
    assign w_free  = ~r_ovalid | i_m_tready;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    assign w_hole[0] = 1'b0;
    assign w_crun[0] = 1'b1;

    // slot chain
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        ceq_pkg::t_entry w_prev, w_next;
        assign w_prev = (g == 0) ? '0 : w_ent[(g == 0) ? 0 : g - 1];
        assign w_next = (g == QUEUE_DEPTH - 1) ? '0 : w_ent[(g == QUEUE_DEPTH - 1) ? g : g + 1];
        ceq_cell #(.IDX(g), .CW(CW)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_fill     (r_fill),
            .i_ins_pos  (w_ins_pos),
            .i_prev     (w_prev),
            .i_next     (w_next),
            .i_new      (w_new),
            .i_hole_in  (w_hole[g]),
            .o_hole_out (w_hole[g+1]),
            .i_crun_in  (w_crun[g]),
            .o_crun_out (w_crun[g+1]),
            .o_pending  (w_pend[g]),
            .o_entry    (w_ent[g])
        );
    end

    // marked draw rectangle
    always_comb begin
        w_mrect = '0;
        w_have  = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (w_ent[i].valid && w_ent[i].dm) begin
                w_mrect = w_mrect | w_ent[i].rect;
                w_have  = 1'b1;
            end
        end
    end

    ceq_union u_union (
        .i_clk  (i_clk),
        .i_a    (r_old),
        .i_a_ok (r_have_old),
        .i_b    (r_rect),
        .o_res  (w_urect)
    );

    // new entry
    always_comb begin
        w_new.valid = 1'b1;
        w_new.kind  = r_kind;
        w_new.mv    = (r_kind == ceq_pkg::K_MOTION) ? r_mv : 1'b0;
        w_new.rect  = (r_kind == ceq_pkg::K_DRAW) ? w_urect : '0;
        w_new.tag   = r_tag;
        w_new.dm    = (r_kind == ceq_pkg::K_DRAW);
        w_new.vm    = (r_kind == ceq_pkg::K_VIEW);
        w_ins_pos   = (r_kind == ceq_pkg::K_SDESTROY) ? '0 : r_fill;
    end

    // commands to the chain
    always_comb begin
        w_ctl = '0;
        case (r_state)
            S_DECIDE: begin
                if (r_op == ceq_pkg::OP_POP) begin
                    w_ctl.kill_head = ~w_empty;
                end else if (!w_full) begin
                    w_ctl.kill_create   = (r_kind == ceq_pkg::K_SDESTROY);
                    w_ctl.kill_dmark    = (r_kind == ceq_pkg::K_DRAW);
                    w_ctl.kill_vmark    = (r_kind == ceq_pkg::K_VIEW);
                    w_ctl.kill_lastmove = (r_kind == ceq_pkg::K_MOTION) && r_mv;
                end
            end
            S_COMPACT: begin
                w_ctl.compact = |w_pend;
            end
            S_INSERT: begin
                w_ctl.insert    = 1'b1;
                w_ctl.ins_run   = (r_kind == ceq_pkg::K_CPAUSE) ||
                                  (r_kind == ceq_pkg::K_CRESUME);
                w_ctl.clr_vmark = (r_kind != ceq_pkg::K_DRAW) &&
                                  (r_kind != ceq_pkg::K_VIEW) &&
                                  (r_kind != ceq_pkg::K_POKE);
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_s_tvalid) n_state = S_DECIDE;
            S_DECIDE: begin
                if ((r_op == ceq_pkg::OP_POP && w_empty) ||
                    (r_op == ceq_pkg::OP_POST && w_full)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_COMPACT;
                end
            end
            S_COMPACT: begin
                if (!(|w_pend)) begin
                    if (r_op == ceq_pkg::OP_POP) begin
                        n_state = S_DONE;
                    end else if (r_kind == ceq_pkg::K_DRAW) begin
                        n_state = S_UNION;
                    end else begin
                        n_state = S_INSERT;
                    end
                end
            end
            S_UNION:   n_state = S_INSERT;
            S_INSERT:  n_state = S_DONE;
            S_DONE:    if (w_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_COMPACT && (|w_pend)) begin
                r_fill <= r_fill - 1'b1;
            end else if (r_state == S_INSERT) begin
                r_fill <= r_fill + 1'b1;
            end
            if (r_state == S_DONE && w_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // item, result and output beat
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_op   <= i_s_tuser[0];
            r_kind <= i_s_tuser[4:1];
            r_mv   <= i_s_tdata[0];
            r_rect <= {i_s_tdata[16:1], i_s_tdata[32:17], i_s_tdata[47:33], i_s_tdata[62:48]};
            r_tag  <= i_s_tdata[78:63];
        end
        if (r_state == S_DECIDE) begin
            r_old      <= w_mrect;
            r_have_old <= w_have;
            r_drop     <= '0;
            if (r_op == ceq_pkg::OP_POP) begin
                r_ok   <= ~w_empty;
                r_full <= 1'b0;
                r_rent <= w_empty ? '0 : w_ent[0];
            end else begin
                r_ok   <= ~w_full;
                r_full <= w_full;
                r_rent <= '0;
            end
        end
        if (r_state == S_COMPACT && (|w_pend) && r_op == ceq_pkg::OP_POST &&
            r_drop != '1) begin
            r_drop <= r_drop + 1'b1;
        end
        if (r_state == S_DONE && w_free) begin
            r_ouser <= {r_rent.kind, r_full, r_ok};
            r_odata <= {4'b0000, r_drop, r_rent.tag, r_rent.rect.h, r_rent.rect.w,
                        r_rent.rect.y, r_rent.rect.x, r_rent.mv};
        end
    end

endmodule

### rtl/ceq_checker.sv
// ============================================================================
// ceq_checker - port-level checks for the coalescing event queue
// Watches the result channel and binds to the top level.
// ============================================================================
module ceq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [87:0] o_m_tdata,
    input logic [5:0]  o_m_tuser
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // accepted and rejected never together
    a_okfull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("ok and full both set");

    // a rejected post removes nothing and returns no entry
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tdata[83:79] == 5'd0 && o_m_tuser[5:2] == 4'd0)
        else $error("rejected post reports data");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind coalescing_event_queue ceq_checker u_ceq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
